[rtl/wczc_pkg.sv]
// Shared types, widths and register codes for the windowed call z-score classifier.
package wczc_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int POS_WIDTH   = 31;
    localparam int PROB_WIDTH  = 16;
    localparam int GAP_WIDTH   = 16;
    localparam int RES_WIDTH   = 20;
    localparam int Z_WIDTH     = 32;
    localparam int FRAC_BITS   = 16;

    // z-score datapath widths
    localparam int MUL1_WIDTH  = COUNT_WIDTH + FRAC_BITS;       // A*f and C<<16
    localparam int D_WIDTH     = MUL1_WIDTH + FRAC_BITS;        // A*f*(1-f)
    localparam int ROOT_WIDTH  = D_WIDTH / 2;
    localparam int QUO_WIDTH   = MUL1_WIDTH + FRAC_BITS;        // (mag<<16)/s
    localparam int SQRT_STEPS  = D_WIDTH / 2;
    localparam int DIV_STEPS   = QUO_WIDTH;
    localparam int STEP_WIDTH  = $clog2(DIV_STEPS + 1);

    // resolution/10 through a reciprocal multiply, exact for 20-bit values
    localparam int DIV10_WIDTH = RES_WIDTH - 3;
    localparam int DIV10_SHIFT = 23;
    localparam logic [RES_WIDTH-1:0] DIV10_MUL = RES_WIDTH'(838861);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register map
    localparam int ADDR_WIDTH = 5;
    localparam logic [2:0] REG_CALL_THR = 3'd0;
    localparam logic [2:0] REG_COOLDOWN = 3'd1;
    localparam logic [2:0] REG_WIN_RES  = 3'd2;
    localparam logic [2:0] REG_FRACTION = 3'd3;
    localparam logic [2:0] REG_Z_THR    = 3'd4;

    localparam logic [GAP_WIDTH-1:0]  RST_CALL_THR = GAP_WIDTH'(52429);
    localparam logic [GAP_WIDTH-1:0]  RST_COOLDOWN = GAP_WIDTH'(4);
    localparam logic [RES_WIDTH-1:0]  RST_WIN_RES  = RES_WIDTH'(100);
    localparam logic [DIV10_WIDTH-1:0] RST_RES_DIV10 = DIV10_WIDTH'(10);
    localparam logic [PROB_WIDTH-1:0] RST_FRACTION = PROB_WIDTH'(32768);

    typedef struct packed {
        logic                  mode;
        logic [POS_WIDTH-1:0]  position;
        logic [PROB_WIDTH-1:0] analogue_prob;
    } t_in_word;

    typedef struct packed {
        logic [POS_WIDTH-1:0]      region_start;
        logic [POS_WIDTH-1:0]      region_end;
        logic signed [Z_WIDTH-1:0] region_score;
        logic                      is_positive;
    } t_out_word;

    typedef struct packed {
        logic [PROB_WIDTH-1:0]     call_threshold;
        logic [GAP_WIDTH-1:0]      cooldown_gap;
        logic [RES_WIDTH-1:0]      window_resolution;
        logic [DIV10_WIDTH-1:0]    res_div10;
        logic [PROB_WIDTH-1:0]     analogue_fraction;
        logic signed [Z_WIDTH-1:0] z_threshold;
    } t_cfg;

    typedef struct packed {
        logic [POS_WIDTH-1:0]   region_start;
        logic [POS_WIDTH-1:0]   region_end;
        logic [COUNT_WIDTH-1:0] call_count;
        logic [COUNT_WIDTH-1:0] attempt_count;
    } t_job;

endpackage

[rtl/wczc_front.sv]
// Front part: counts calls and attempts per record and closes windows into jobs.
module wczc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wczc_pkg::t_in_word i_in_word,
    input  wczc_pkg::t_cfg    i_cfg,
    output logic              o_job_valid,
    output wczc_pkg::t_job    o_job,
    input  logic              i_job_ready
);

    localparam logic [wczc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [wczc_pkg::COUNT_WIDTH-1:0] r_call, n_call, r_att, n_att;
    logic [wczc_pkg::POS_WIDTH-1:0]   r_last_call, r_last_att, r_win_start;
    logic                             r_win_open;

    logic                             accept, call_far, att_far, is_call, bump_att;
    logic                             span_ok, close_win;
    logic [wczc_pkg::POS_WIDTH-1:0]   pos, win_start;
    logic [wczc_pkg::POS_WIDTH-1:0]   d_call, d_att, d_win;

    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign pos        = i_in_word.position;

    always_comb begin
        d_call    = pos - r_last_call;
        d_att     = pos - r_last_att;
        win_start = r_win_open ? r_win_start : pos;
        d_win     = pos - win_start;
        call_far  = (pos < r_last_call) ||
                    (d_call >= wczc_pkg::POS_WIDTH'(i_cfg.cooldown_gap));
        att_far   = (pos < r_last_att) ||
                    (d_att >= wczc_pkg::POS_WIDTH'(i_cfg.cooldown_gap));
        is_call   = (i_in_word.analogue_prob > i_cfg.call_threshold) && call_far;
        bump_att  = is_call || att_far;
        n_call    = (is_call && r_call != COUNT_MAX) ? r_call + 1'b1 : r_call;
        n_att     = (bump_att && r_att != COUNT_MAX) ? r_att + 1'b1 : r_att;
        span_ok   = (pos < win_start) ||
                    (d_win > wczc_pkg::POS_WIDTH'(i_cfg.window_resolution));
        close_win = span_ok &&
                    (n_att >= wczc_pkg::COUNT_WIDTH'(i_cfg.res_div10));
    end

    assign o_job_valid          = accept & i_in_word.mode & close_win;
    assign o_job.region_start   = win_start;
    assign o_job.region_end     = pos;
    assign o_job.call_count     = n_call;
    assign o_job.attempt_count  = n_att;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call      <= '0;
            r_att       <= '0;
            r_last_call <= '0;
            r_last_att  <= '0;
            r_win_start <= '0;
            r_win_open  <= 1'b0;
        end else if (accept) begin
            if (!i_in_word.mode) begin
                r_call      <= '0;
                r_att       <= '0;
                r_last_call <= '0;
                r_last_att  <= '0;
                r_win_start <= '0;
                r_win_open  <= 1'b0;
            end else begin
                if (is_call) r_last_call <= pos;
                if (bump_att) r_last_att <= pos;
                r_win_start <= win_start;
                if (close_win) begin
                    r_call     <= '0;
                    r_att      <= '0;
                    r_win_open <= 1'b0;
                end else begin
                    r_call     <= n_call;
                    r_att      <= n_att;
                    r_win_open <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/wczc_queue.sv]
// Short job queue between the front and back parts.
module wczc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wczc_pkg::t_job i_job,
    output logic           o_not_full,
    output logic           o_valid,
    output wczc_pkg::t_job o_job,
    input  logic           i_pop
);

    wczc_pkg::t_job               r_mem [wczc_pkg::Q_DEPTH];
    logic [wczc_pkg::Q_AW-1:0]    r_wr, r_rd;
    logic [wczc_pkg::Q_AW:0]      r_cnt;
    logic                         push, pop;

    assign o_not_full = (r_cnt != (wczc_pkg::Q_AW+1)'(wczc_pkg::Q_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];
    assign push       = i_push & o_not_full;
    assign pop        = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[rtl/wczc_back.sv]
// Back part: binomial z-score through serial square root and division.
module wczc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  wczc_pkg::t_job    i_job,
    output logic              o_job_ready,
    input  wczc_pkg::t_cfg    i_cfg,
    output logic              o_out_valid,
    output wczc_pkg::t_out_word o_out_word,
    input  logic              i_out_ready
);

    localparam int MW = wczc_pkg::MUL1_WIDTH;
    localparam int DW = wczc_pkg::D_WIDTH;
    localparam int RW = wczc_pkg::ROOT_WIDTH;
    localparam int QW = wczc_pkg::QUO_WIDTH;
    localparam int ZW = wczc_pkg::Z_WIDTH;
    localparam int SW = wczc_pkg::STEP_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic signed [ZW+1:0] ZMAX = 34'sd2147483647;
    localparam logic signed [ZW+1:0] ZMIN = -34'sd2147483648;

    logic [2:0]          r_state;
    wczc_pkg::t_job      r_job;
    logic [MW-1:0]       r_nf, r_pc, r_mag;
    logic                r_neg;
    logic [DW-1:0]       r_rem, r_root;
    logic [RW-1:0]       r_s, r_prem;
    logic [SW-1:0]       r_cnt;
    logic                r_out_valid;
    wczc_pkg::t_out_word r_out;

    logic [DW-1:0]           bit_w, trial;
    logic [DW+wczc_pkg::FRAC_BITS:0] prod2;
    logic [RW:0]             dtrial;
    logic                    dbit, over, out_free;
    logic signed [ZW-1:0]    z;
    logic signed [ZW:0]      absthr;
    logic signed [ZW+1:0]    sum;
    logic signed [ZW-1:0]    score;
    logic [ZW-1:0]           qlo;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        bit_w  = DW'(1) << {r_cnt, 1'b0};
        trial  = r_root + bit_w;
        prod2  = r_nf * (((wczc_pkg::FRAC_BITS+1)'(1) << wczc_pkg::FRAC_BITS)
                         - (wczc_pkg::FRAC_BITS+1)'(i_cfg.analogue_fraction));
        dtrial = {r_prem, r_rem[QW-1]};
        dbit   = (dtrial >= {1'b0, r_s});
        // quotient in r_rem after division
        over   = |r_rem[QW-1:ZW];
        qlo    = r_rem[ZW-1:0];
        if (r_s == '0) begin
            z = '0;
        end else if (r_neg) begin
            if (over || qlo > 32'h8000_0000) z = ZMIN[ZW-1:0];
            else z = ZW'(~qlo + 1'b1);
        end else begin
            if (over || qlo[ZW-1]) z = ZMAX[ZW-1:0];
            else z = qlo;
        end
        absthr = i_cfg.z_threshold[ZW-1] ? -(ZW+1)'(i_cfg.z_threshold)
                                         : (ZW+1)'(i_cfg.z_threshold);
        sum    = (ZW+2)'(z) + (ZW+2)'(absthr);
        if (sum > ZMAX) score = ZMAX[ZW-1:0];
        else if (sum < ZMIN) score = ZMIN[ZW-1:0];
        else score = sum[ZW-1:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (i_job_valid) r_job <= i_job;
            S_MUL1: begin
                r_nf <= MW'(r_job.attempt_count * i_cfg.analogue_fraction);
                r_pc <= {r_job.call_count, {wczc_pkg::FRAC_BITS{1'b0}}};
            end
            S_MUL2: begin
                r_rem  <= prod2[DW-1:0];
                r_root <= '0;
                r_neg  <= (r_nf > r_pc);
                r_mag  <= (r_nf > r_pc) ? r_nf - r_pc : r_pc - r_nf;
            end
            S_SQRT: begin
                if (r_cnt == '0) begin
                    r_s    <= (r_rem >= trial) ? RW'((r_root >> 1) + bit_w)
                                               : RW'(r_root >> 1);
                    r_rem  <= {r_mag, {wczc_pkg::FRAC_BITS{1'b0}}};
                    r_prem <= '0;
                end else if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + bit_w;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            S_DIV: begin
                r_prem <= dbit ? RW'(dtrial - {1'b0, r_s}) : RW'(dtrial);
                r_rem  <= {r_rem[QW-2:0], dbit};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: begin
                    r_state <= S_SQRT;
                    r_cnt   <= SW'(wczc_pkg::SQRT_STEPS - 1);
                end
                S_SQRT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DIV;
                        r_cnt   <= SW'(wczc_pkg::DIV_STEPS - 1);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) r_state <= S_FIN;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_FIN: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out.region_start <= r_job.region_start;
            r_out.region_end   <= r_job.region_end;
            r_out.region_score <= score;
            r_out.is_positive  <= (z > i_cfg.z_threshold);
        end
    end

endmodule

[rtl/windowed_call_zscore_classifier_top.sv]
// Top level: configuration registers, front counter, job queue and z-score back end.
// Flow: with an idle back end, a window-closing record passes the job take, multiply,
// serial square root, serial division and output load before its word appears.
// Throughput: one record per cycle while the queue has room; the back end serves one
// window at a time; a four-entry queue absorbs closing bursts before input stalls.
// Reset (i_rst_n low, synchronous): registers return to their defaults, counts,
// window and cooldown positions clear, queue and output empty.
module windowed_call_zscore_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // record channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  wczc_pkg::t_in_word           i_in_word,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output wczc_pkg::t_out_word          o_out_word,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wczc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    wczc_pkg::t_cfg r_cfg;
    logic           cfg_wr;
    logic [2:0]     reg_idx;
    logic [2*wczc_pkg::RES_WIDTH-1:0] div10_prod;

    logic           job_valid, job_not_full, q_valid, q_pop;
    wczc_pkg::t_job job_in, job_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Precompute resolution/10 at write time so the front sees a plain compare.
    assign div10_prod = pwdata[wczc_pkg::RES_WIDTH-1:0] * wczc_pkg::DIV10_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.call_threshold    <= wczc_pkg::RST_CALL_THR;
            r_cfg.cooldown_gap      <= wczc_pkg::RST_COOLDOWN;
            r_cfg.window_resolution <= wczc_pkg::RST_WIN_RES;
            r_cfg.res_div10         <= wczc_pkg::RST_RES_DIV10;
            r_cfg.analogue_fraction <= wczc_pkg::RST_FRACTION;
            r_cfg.z_threshold       <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                wczc_pkg::REG_CALL_THR: r_cfg.call_threshold <= pwdata[15:0];
                wczc_pkg::REG_COOLDOWN: r_cfg.cooldown_gap   <= pwdata[15:0];
                wczc_pkg::REG_WIN_RES: begin
                    r_cfg.window_resolution <= pwdata[wczc_pkg::RES_WIDTH-1:0];
                    r_cfg.res_div10 <= div10_prod[wczc_pkg::DIV10_SHIFT +:
                                                  wczc_pkg::DIV10_WIDTH];
                end
                wczc_pkg::REG_FRACTION: r_cfg.analogue_fraction <= pwdata[15:0];
                wczc_pkg::REG_Z_THR:    r_cfg.z_threshold <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        unique case (reg_idx)
            wczc_pkg::REG_CALL_THR: prdata = 32'(r_cfg.call_threshold);
            wczc_pkg::REG_COOLDOWN: prdata = 32'(r_cfg.cooldown_gap);
            wczc_pkg::REG_WIN_RES:  prdata = 32'(r_cfg.window_resolution);
            wczc_pkg::REG_FRACTION: prdata = 32'(r_cfg.analogue_fraction);
            wczc_pkg::REG_Z_THR:    prdata = r_cfg.z_threshold;
            default:                prdata = '0;
        endcase
    end

    // Front: one record per cycle, stalls only when the job queue is full.
    wczc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .i_job_ready (job_not_full)
    );

    wczc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (job_valid),
        .i_job      (job_in),
        .o_not_full (job_not_full),
        .o_valid    (q_valid),
        .o_job      (job_out),
        .i_pop      (q_pop)
    );

    // Back: serial z-score, holds its word in an output register.
    wczc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_job_ready (q_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

endmodule

[dv/testbench.sv]
// Testbench for the windowed call z-score classifier: directed table, random reads, predictor check.
`timescale 1ns / 1ps
module testbench;

    localparam int HOLD_CYCLES  = 600;
    localparam int WDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [63:0] CNT_MAX = (64'd1 << wczc_pkg::COUNT_WIDTH) - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    wczc_pkg::t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    wczc_pkg::t_out_word   o_out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [wczc_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    windowed_call_zscore_classifier_top dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [63:0] m_thr, m_gap, m_res, m_frac;
    logic signed [63:0] m_zthr;
    logic [63:0] m_calls, m_atts, m_last_call, m_last_att, m_win_start;
    logic        m_win_open;

    wczc_pkg::t_out_word   region_q[$];
    int          n_fail = 0;
    int          idle_cnt = 0;
    bit          quiet = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;
    int          rx_burst = 0;

    function automatic bit far_enough(logic [63:0] p, logic [63:0] r, logic [63:0] g);
        if (p < r) return 1'b1;
        return (p - r) >= g;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] d);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > d) bitv >>= 2;
        while (bitv != 0) begin
            if (d >= root + bitv) begin
                d = d - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] binom_z(logic [63:0] c, logic [63:0] a,
                                                   logic [63:0] f);
        logic [63:0] hit, base, s, mag, q1, r, q;
        bit neg;
        if (a == 0 || f == 0) return 0;
        s = root_floor(a * f * (64'd65536 - f));
        if (s == 0) return 0;
        hit  = c << 16;
        base = a * f;
        neg  = base > hit;
        mag  = neg ? base - hit : hit - base;
        q1   = mag / s;
        r    = mag % s;
        if (q1 >= 65536) return neg ? -64'sd2147483648 : 64'sd2147483647;
        q = (q1 << 16) + ((r << 16) / s);
        return clip32(neg ? -$signed(q) : $signed(q));
    endfunction

    function automatic void clear_read();
        m_calls = 0; m_atts = 0; m_win_open = 0;
        m_last_call = 0; m_last_att = 0; m_win_start = 0;
    endfunction

    // advance predictor by one record; return 1 when a window closes
    function automatic bit score_record(wczc_pkg::t_in_word w,
                                        output wczc_pkg::t_out_word res);
        logic [63:0] p, pr;
        logic signed [63:0] z, absthr;
        res = '0;
        p  = 64'(w.position);
        pr = 64'(w.analogue_prob);
        if (!w.mode) begin
            clear_read();
            return 0;
        end
        if (pr > m_thr && far_enough(p, m_last_call, m_gap)) begin
            m_last_att = p; m_last_call = p;
            if (m_calls < CNT_MAX) m_calls++;
            if (m_atts < CNT_MAX) m_atts++;
        end else if (far_enough(p, m_last_att, m_gap)) begin
            if (m_atts < CNT_MAX) m_atts++;
            m_last_att = p;
        end
        if (!m_win_open) begin
            m_win_start = p;
            m_win_open = 1;
        end
        if (!far_enough(p, m_win_start, m_res + 1)) return 0;
        if (m_atts < m_res / 10) return 0;
        z = binom_z(m_calls, m_atts, m_frac);
        absthr = (m_zthr < 0) ? -m_zthr : m_zthr;
        res.region_start = m_win_start[wczc_pkg::POS_WIDTH-1:0];
        res.region_end   = w.position;
        res.region_score = 32'(clip32(z + absthr));
        res.is_positive  = z > m_zthr;
        m_calls = 0; m_atts = 0; m_win_open = 0;
        return 1;
    endfunction

    // receiver: random stall bursts, long hold-off on request, none when quiet
    always @(posedge i_clk) begin
        if (hold_req) begin
            i_out_ready <= 1'b0;
            hold_cnt = hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES) begin
                hold_req = 0;
                hold_cnt = 0;
            end
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_burst = $urandom_range(1, 7) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // check every accepted result word against the oldest expected region
    always @(posedge i_clk) begin
        wczc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (region_q.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                n_fail++;
            end else begin
                want = region_q.pop_front();
                if (o_out_word.region_start !== want.region_start) begin
                    $error("region_start exp %h got %h", want.region_start,
                           o_out_word.region_start);
                    n_fail++;
                end
                if (o_out_word.region_end !== want.region_end) begin
                    $error("region_end exp %h got %h", want.region_end,
                           o_out_word.region_end);
                    n_fail++;
                end
                if (o_out_word.region_score !== want.region_score) begin
                    $error("region_score exp %h got %h", want.region_score,
                           o_out_word.region_score);
                    n_fail++;
                end
                if (o_out_word.is_positive !== want.is_positive) begin
                    $error("is_positive exp %b got %b", want.is_positive,
                           o_out_word.is_positive);
                    n_fail++;
                end
            end
        end
    end

    // watchdog: count cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= wczc_pkg::ADDR_WIDTH'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            wczc_pkg::REG_CALL_THR: m_thr  = 64'(val[15:0]);
            wczc_pkg::REG_COOLDOWN: m_gap  = 64'(val[15:0]);
            wczc_pkg::REG_WIN_RES:  m_res  = 64'(val[19:0]);
            wczc_pkg::REG_FRACTION: m_frac = 64'(val[15:0]);
            wczc_pkg::REG_Z_THR:    m_zthr = 64'($signed(val));
            default: ;
        endcase
    endtask

    // wait until the block has drained, then rewrite all registers
    task automatic set_config(logic [31:0] thr, logic [31:0] gap, logic [31:0] res,
                              logic [31:0] frac, logic [31:0] zthr);
        i_in_valid <= 1'b0;
        wait (region_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        reg_write(wczc_pkg::REG_CALL_THR, thr);
        reg_write(wczc_pkg::REG_COOLDOWN, gap);
        reg_write(wczc_pkg::REG_WIN_RES, res);
        reg_write(wczc_pkg::REG_FRACTION, frac);
        reg_write(wczc_pkg::REG_Z_THR, zthr);
    endtask

    // offer one record, hold it until accepted; typed expectation overrides prediction
    task automatic send_record(wczc_pkg::t_in_word w, bit typed = 0,
                               wczc_pkg::t_out_word typed_res = '0);
        wczc_pkg::t_out_word res;
        int gap_cyc;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_cyc = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap_cyc) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (score_record(w, res)) region_q.insert(region_q.size(), typed ? typed_res : res);
    endtask

    // one read: a start marker then mostly rising positions
    task automatic random_read(int n);
        wczc_pkg::t_in_word w;
        logic [30:0] p;
        int maxstep;
        w = '0;
        w.mode = 1'b0;
        w.position = 31'($urandom);
        w.analogue_prob = 16'($urandom);
        send_record(w);
        p = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5000));
        maxstep = (m_gap < 64) ? 2 * int'(m_gap) + 3 : 300;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) p = 31'($urandom);
            else p = p + 31'($urandom_range(0, maxstep));
            w.mode = ($urandom_range(0, 99) != 0);
            w.position = p;
            w.analogue_prob = $urandom_range(0, 1) ? 16'($urandom)
                            : 16'(m_thr + $urandom_range(0, 3));
            send_record(w);
        end
    endtask

    task automatic random_phase(int items, bit pause_mid);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(5, 60);
            random_read(n);
            sent += n + 1;
            if (pause_mid && sent >= items / 2) begin
                pause_mid = 0;
                i_in_valid <= 1'b0;
                wait (region_q.size() == 0);
            end
        end
    endtask

    typedef struct {
        logic        mode;
        logic [30:0] pos;
        logic [15:0] prob;
        bit          typed;
        wczc_pkg::t_out_word res;
    } t_row;

    t_row rows[$] = '{
        '{1'b0, 31'h7FFFFFFF, 16'hFFFF, 0, '0},
        '{1'b1, 31'd10, 16'h0000, 0, '0},
        '{1'b1, 31'd12, 16'h0000, 1, '{31'd10, 31'd12, 32'hFFFF0000, 1'b0}},
        '{1'b1, 31'h7FFFFFFF, 16'hFFFF, 0, '0},
        '{1'b1, 31'd0, 16'h0000, 1, '{31'h7FFFFFFF, 31'd0, 32'h0, 1'b0}},
        '{1'b0, 31'd0, 16'h0000, 0, '0},
        '{1'b1, 31'd100, 16'hFFFF, 0, '0},
        '{1'b1, 31'd101, 16'hFFFF, 0, '0},
        '{1'b1, 31'd104, 16'd52429, 0, '0},
        '{1'b1, 31'd104, 16'd52430, 0, '0},
        '{1'b1, 31'd200, 16'h0000, 0, '0},
        '{1'b1, 31'h7FFFFFFE, 16'h0001, 0, '0},
        '{1'b1, 31'h55555555, 16'hAAAA, 0, '0},
        '{1'b1, 31'h2AAAAAAA, 16'h5555, 0, '0}
    };

    initial begin
        wczc_pkg::t_in_word w;
        m_thr = 52429; m_gap = 4; m_res = 100; m_frac = 32768; m_zthr = 0;
        clear_read();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: resolution 1 so windows close quickly
        set_config(52429, 4, 1, 32768, 0);
        foreach (rows[i]) begin
            w.mode = rows[i].mode;
            w.position = rows[i].pos;
            w.analogue_prob = rows[i].prob;
            send_record(w, rows[i].typed, rows[i].res);
        end

        // fill the queue while the receiver holds off
        set_config(0, 0, 1, 1, 32'h7FFFFFFF);
        hold_req = 1;
        random_phase(300, 0);
        set_config(65535, 65535, 30, 65535, 32'h80000000);
        random_phase(200, 0);
        set_config(40000, 3, 50, 0, 32'hFFFE0000);
        random_phase(250, 1);
        set_config(20000, 1, 1048575, 100, 32'h00010000);
        random_phase(60, 0);
        set_config(30000, 2, 20, 20000, 32'h00008000);
        random_phase(400, 0);
        set_config(52429, 4, 40, 32768, 0);
        quiet = 1;
        random_phase(350, 0);

        i_in_valid <= 1'b0;
        wait (region_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
